[src/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Depends on a clk / rst_n pair in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of clk, off while reset is held.
`define DBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication form: antecedent on one edge, consequent on the next.
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DBD_ASSERT(lbl, prop, msg)
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/dbd_pkg.sv]
// Shared types, codes and constants of the debug block deframer.
// No dependencies; used by every module in src.
package dbd_pkg;

    localparam int unsigned LEN_W = 24;

    localparam logic [31:0] MAGIC_WORD   = 32'h444D_4140;  // "DMA@"
    localparam logic [31:0] TRAILER_WORD = 32'h434D_5048;  // "CMPH"
    localparam logic [LEN_W-1:0] LIMIT_RESET = 24'd512;

    // phase codes
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    // result status codes
    localparam logic [2:0] ST_DATA  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_MAGIC = 3'd2;
    localparam logic [2:0] ST_LONG  = 3'd3;
    localparam logic [2:0] ST_ALIGN = 3'd4;
    localparam logic [2:0] ST_TRAIL = 3'd5;

    // configuration register indexes
    localparam logic REG_ENABLE     = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    typedef struct packed {
        logic             enable;
        logic [LEN_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [7:0] block_kind;
        logic       last_payload;
        logic [2:0] status;
    } res_t;

endpackage

[src/debug_block_deframer_core.sv]
// Top level of the debug block deframer: input register, decode, result register.
// Depends on dbd_pkg, dbd_cfg, dbd_parse and assert_macros.svh.
//
//   channel  direction  handshake             payload
//   rx       in         rx_valid / rx_stall   rx_byte
//   out      out        out_valid / out_stall data_byte, block_kind, last_payload, status
//   cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per clock while out_stall is low; out_valid comes from the result register.
// Each byte is decoded by the combinational logic between the input and result registers.
// An out stall holds the result register; an empty input register takes one more byte.
// Reset clears control and deframing state; hunting starts with enable set and limit 512.
`include "assert_macros.svh"
module debug_block_deframer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                data_byte,
    output logic [7:0]                block_kind,
    output logic                      last_payload,
    output logic [2:0]                status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [dbd_pkg::LEN_W-1:0] cfg_data
);
    import dbd_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_reg;
    logic       advance;
    logic       rx_take;

    dbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dbd_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .byte_in (s1_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // decode moves on whenever the result register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign rx_stall = s1_valid_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && res.valid)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            s1_byte_reg <= rx_byte;
        if (advance && res.valid)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = out_reg.data_byte;
    assign block_kind   = out_reg.block_kind;
    assign last_payload = out_reg.last_payload;
    assign status       = out_reg.status;

    `DBD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && out_valid_reg && out_stall, s1_valid_reg && $stable(s1_byte_reg), "input byte lost under stall")
    `DBD_ASSERT(a_out_drop, !$fell(out_valid_reg) || $past(!out_stall), "result dropped without transfer")
    `DBD_ASSERT(a_out_source, !$rose(out_valid_reg) || $past(s1_valid_reg), "result without a pending byte")

endmodule

[src/dbd_cfg.sv]
// Configuration registers of the deframer: enable and payload length limit.
// Depends on dbd_pkg.
module dbd_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [dbd_pkg::LEN_W-1:0] cfg_data,
    output dbd_pkg::cfg_t            cfg
);
    import dbd_pkg::*;

    logic             enable_reg;
    logic [LEN_W-1:0] max_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            max_length_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg.enable     = enable_reg;
    assign cfg.max_length = max_length_reg;

endmodule

[src/dbd_parse.sv]
// Deframing state and per-byte decode: magic, header, payload, trailer.
// Depends on dbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dbd_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    byte_in,
    input  dbd_pkg::cfg_t cfg,
    output dbd_pkg::res_t res
);
    import dbd_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       group_count_reg, group_count_next;
    logic [23:0]      word_shift_reg, word_shift_next;
    logic [LEN_W-1:0] payload_left_reg, payload_left_next;
    logic [7:0]       held_kind_reg, held_kind_next;

    logic [31:0]      word;
    logic [LEN_W-1:0] len;
    logic             full;
    logic             last;

    // only the last three bytes of a group need storing
    assign word = {word_shift_reg, byte_in};
    assign len  = word[LEN_W-1:0];
    assign full = (group_count_reg == 2'd3);
    assign last = (payload_left_reg <= 24'd1);

    always_comb
    begin
        phase_next        = phase_reg;
        group_count_next  = group_count_reg;
        word_shift_next   = word_shift_reg;
        payload_left_next = payload_left_reg;
        held_kind_next    = held_kind_reg;
        res               = '0;

        if (cfg.enable)
        begin
            if (phase_reg == PH_PAYLOAD)
            begin
                res.valid        = 1'b1;
                res.data_byte    = byte_in;
                res.block_kind   = held_kind_reg;
                res.last_payload = last;
                res.status       = ST_DATA;
                if (last)
                begin
                    payload_left_next = '0;
                    phase_next        = PH_TRAILER;
                    group_count_next  = 2'd0;
                end
                else
                begin
                    payload_left_next = payload_left_reg - 24'd1;
                end
            end
            else
            begin
                word_shift_next  = word[23:0];
                group_count_next = group_count_reg + 2'd1;
                if (full)
                begin
                    phase_next = PH_HUNT;
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            held_kind_next = word[31:24];
                            if (len > cfg.max_length)
                            begin
                                res.valid      = 1'b1;
                                res.block_kind = word[31:24];
                                res.status     = ST_LONG;
                            end
                            else if (len[1:0] != 2'd0)
                            begin
                                res.valid      = 1'b1;
                                res.block_kind = word[31:24];
                                res.status     = ST_ALIGN;
                            end
                            else
                            begin
                                payload_left_next = len;
                                phase_next = (len == '0) ? PH_TRAILER : PH_PAYLOAD;
                            end
                        end
                        PH_TRAILER:
                        begin
                            res.valid      = 1'b1;
                            res.block_kind = held_kind_reg;
                            res.status     = (word == TRAILER_WORD) ? ST_OK : ST_TRAIL;
                        end
                        default:
                        begin
                            if (word == MAGIC_WORD)
                                phase_next = PH_HEADER;
                            else
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_MAGIC;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            group_count_reg  <= 2'd0;
            word_shift_reg   <= '0;
            payload_left_reg <= '0;
            held_kind_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            group_count_reg  <= group_count_next;
            word_shift_reg   <= word_shift_next;
            payload_left_reg <= payload_left_next;
            held_kind_reg    <= held_kind_next;
        end
    end

    `DBD_ASSERT(a_payload_left_nonzero, (phase_reg != PH_PAYLOAD) || (payload_left_reg != '0), "payload phase with nothing left")
    `DBD_ASSERT(a_payload_group_clear, (phase_reg != PH_PAYLOAD) || (group_count_reg == 2'd0), "group count not cleared in payload")
    `DBD_ASSERT_NEXT(a_kind_held, phase_reg == PH_PAYLOAD, (phase_reg != PH_PAYLOAD) || $stable(held_kind_reg), "block kind changed mid payload")

endmodule

[tb/tb.sv]
// Self-checking testbench for debug_block_deframer_core: directed table, then random frames.
// Depends on dbd_pkg; expected results: table rows or an in-file deframing predictor.
module tb;
    import dbd_pkg::*;

    typedef struct packed {
        logic [7:0] rx;
        res_t       want;   // want.valid set: expected result typed in by hand
    } dir_row_t;

    localparam res_t NO_CHECK   = '0;
    localparam res_t WANT_MAGIC = {1'b1, 8'h00, 8'h00, 1'b0, ST_MAGIC};
    localparam res_t WANT_OK_FF = {1'b1, 8'h00, 8'hFF, 1'b0, ST_OK};
    localparam res_t WANT_LONG  = {1'b1, 8'h00, 8'h00, 1'b0, ST_LONG};

    localparam int DIR_ROWS = 24;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // all-ones group while hunting
        {8'hFF, NO_CHECK}, {8'hFF, NO_CHECK}, {8'hFF, NO_CHECK}, {8'hFF, WANT_MAGIC},
        // zero-length block of kind 0xFF: header straight into trailer
        {8'h44, NO_CHECK}, {8'h4D, NO_CHECK}, {8'h41, NO_CHECK}, {8'h40, NO_CHECK},
        {8'hFF, NO_CHECK}, {8'h00, NO_CHECK}, {8'h00, NO_CHECK}, {8'h00, NO_CHECK},
        {8'h43, NO_CHECK}, {8'h4D, NO_CHECK}, {8'h50, NO_CHECK}, {8'h48, WANT_OK_FF},
        // length 513: over the limit and unaligned, limit check wins
        {8'h44, NO_CHECK}, {8'h4D, NO_CHECK}, {8'h41, NO_CHECK}, {8'h40, NO_CHECK},
        {8'h00, NO_CHECK}, {8'h00, NO_CHECK}, {8'h02, NO_CHECK}, {8'h01, WANT_LONG}
    };

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             rx_valid  = 1'b0;
    logic             rx_stall;
    logic [7:0]       rx_byte   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       data_byte;
    logic [7:0]       block_kind;
    logic             last_payload;
    logic [2:0]       status;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = REG_ENABLE;
    logic [LEN_W-1:0] cfg_data  = '0;

    debug_block_deframer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .block_kind   (block_kind),
        .last_payload (last_payload),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state and its copy of the registers
    logic             cfg_en  = 1'b1;
    logic [LEN_W-1:0] cfg_max = LIMIT_RESET;
    logic [1:0]       ph      = PH_HUNT;
    logic [1:0]       grp     = '0;
    logic [31:0]      shreg   = '0;
    logic [LEN_W-1:0] left    = '0;
    logic [7:0]       kind    = '0;

    res_t pending_q [$];
    int   n_err   = 0;
    int   n_items = 0;
    bit   idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_err++;
        if (n_err <= 200)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void enter_phase(input logic [1:0] p);
        ph    = p;
        grp   = '0;
        shreg = '0;
    endfunction

    // One received byte through the deframer; returns the result it causes, if any.
    function automatic res_t deframe_byte(input logic [7:0] b);
        res_t             r;
        logic             full;
        logic [LEN_W-1:0] len;
        r = '0;
        if (!cfg_en)
            return r;
        if (ph == PH_PAYLOAD)
        begin
            r.valid        = 1'b1;
            r.data_byte    = b;
            r.block_kind   = kind;
            r.last_payload = (left <= 1);
            r.status       = ST_DATA;
            if (left <= 1)
            begin
                left = '0;
                enter_phase(PH_TRAILER);
            end
            else
                left = left - 1'b1;
            return r;
        end
        shreg = {shreg[23:0], b};
        full  = (grp == 2'd3);
        grp   = grp + 1'b1;
        if (!full)
            return r;
        case (ph)
            PH_HEADER:
            begin
                kind = shreg[31:24];
                len  = shreg[23:0];
                if (len > cfg_max)
                begin
                    r.valid      = 1'b1;
                    r.block_kind = kind;
                    r.status     = ST_LONG;
                    enter_phase(PH_HUNT);
                end
                else if (len[1:0] != 2'd0)
                begin
                    r.valid      = 1'b1;
                    r.block_kind = kind;
                    r.status     = ST_ALIGN;
                    enter_phase(PH_HUNT);
                end
                else
                begin
                    left = len;
                    enter_phase((len == 0) ? PH_TRAILER : PH_PAYLOAD);
                end
            end
            PH_TRAILER:
            begin
                r.valid      = 1'b1;
                r.block_kind = kind;
                r.status     = (shreg == TRAILER_WORD) ? ST_OK : ST_TRAIL;
                enter_phase(PH_HUNT);
            end
            default:
            begin
                if (shreg == MAGIC_WORD)
                    enter_phase(PH_HEADER);
                else
                begin
                    r.valid  = 1'b1;
                    r.status = ST_MAGIC;
                    enter_phase(PH_HUNT);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input res_t want);
        res_t r;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        if (cfg_en)
            n_items++;
        r = deframe_byte(b);
        if (want.valid)
            r = want;
        if (r.valid)
            pending_q.push_back(r);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8], NO_CHECK);
    endtask

    // sender holds off until every expected result is out, plus pipeline drain
    task automatic settle;
        rx_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ENABLE)
            cfg_en = val[0];
        else
            cfg_max = val;
    endtask

    task automatic send_frame;
        int               sel;
        int               pick;
        logic [31:0]      w;
        logic [LEN_W-1:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            // noise, mostly whole groups, sometimes a broken count
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), NO_CHECK);
            else
                repeat (4 * $urandom_range(1, 2))
                    send_byte(8'($urandom_range(0, 255)), NO_CHECK);
        end
        else
        begin
            // finish whatever is open so the magic lands on a group boundary
            while (!(ph == PH_HUNT && grp == 2'd0))
                send_byte(8'($urandom_range(0, 255)), NO_CHECK);
            w = MAGIC_WORD;
            if (sel < 18)
                w = w ^ (32'h1 << $urandom_range(0, 31));
            send_word(w);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = 24'(4 * $urandom_range(0, 8));
            else if (pick == 7)
                len = 24'(4 * $urandom_range(0, 8) + $urandom_range(1, 3));
            else if (pick == 8)
                len = 24'($urandom_range(0, 24'hFFFFFF)) | 24'h1;
            else if (cfg_max < 64)
                len = cfg_max + 24'($urandom_range(1, 4));
            else
                len = 24'(4 * $urandom_range(1, 8));
            send_word({8'($urandom_range(0, 255)), len});
            while (ph == PH_PAYLOAD)
                send_byte(8'($urandom_range(0, 255)), NO_CHECK);
            if (ph == PH_TRAILER)
            begin
                w = TRAILER_WORD;
                if ($urandom_range(0, 9) == 0)
                    w = w ^ (32'h1 << $urandom_range(0, 31));
                send_word(w);
            end
        end
        if ($urandom_range(0, 39) == 0)
            settle();
    endtask

    task automatic run_until(input int target);
        while (n_items < target)
            send_frame();
    endtask

    // result side: check each transfer, stall in random bursts
    initial
    begin
        int   stall_left;
        res_t got;
        res_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {1'b1, data_byte, block_kind, last_payload, status};
                if (pending_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", got));
                else
                begin
                    want = pending_q.pop_front();
                    if (got.data_byte !== want.data_byte || got.block_kind !== want.block_kind
                        || got.last_payload !== want.last_payload
                        || got.status !== want.status)
                        report_mismatch($sformatf(
                            "data %h kind %h last %b status %0d, want %h %h %b %0d",
                            got.data_byte, got.block_kind, got.last_payload, got.status,
                            want.data_byte, want.block_kind, want.last_payload,
                            want.status));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 18);
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_tab[i].rx, dir_tab[i].want);

        run_until(170);
        write_reg(REG_MAX_LENGTH, '0);
        run_until(230);

        // disabled: bytes are dropped and the deframer state holds
        write_reg(REG_ENABLE, 24'd0);
        repeat (24) send_byte(8'($urandom_range(0, 255)), NO_CHECK);
        write_reg(REG_ENABLE, 24'd1);

        write_reg(REG_MAX_LENGTH, 24'hFFFFFF);
        run_until(380);
        write_reg(REG_MAX_LENGTH, 24'd16);
        run_until(480);
        write_reg(REG_MAX_LENGTH, 24'($urandom_range(0, 40)));
        run_until(540);

        idle_on = 1'b0;
        write_reg(REG_MAX_LENGTH, LIMIT_RESET);
        run_until(580);

        settle();
        if (n_err == 0 && pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
